[sv/utt_pkg.sv]
// Shared types, codes and helper functions for the Unicode to UTF-32 transcoder.
package utt_pkg;

   // Byte-order-mark window; the last byte is the one that resolves the mark
   localparam int unsigned SNIFF_BYTES = 4;
   localparam int unsigned SNIFF_CW    = $clog2(SNIFF_BYTES);

   // Encoding codes (register value and format_in_use)
   localparam logic [2:0] FMT_AUTO  = 3'd0;
   localparam logic [2:0] FMT_UTF8  = 3'd1;
   localparam logic [2:0] FMT_U16LE = 3'd2;
   localparam logic [2:0] FMT_U16BE = 3'd3;
   localparam logic [2:0] FMT_U32LE = 3'd4;
   localparam logic [2:0] FMT_U32BE = 3'd5;

   // Status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NONCHAR     = 3'd1;
   localparam logic [2:0] ST_CONTROL     = 3'd2;
   localparam logic [2:0] ST_LONE_LOW    = 3'd3;
   localparam logic [2:0] ST_BAD_PAIR    = 3'd4;
   localparam logic [2:0] ST_BAD_START   = 3'd5;
   localparam logic [2:0] ST_INCOMPLETE  = 3'd6;
   localparam logic [2:0] ST_UNKNOWN_FMT = 3'd7;

   // Byte-order marks, first byte in element 0
   localparam logic [3:0][7:0] MARK_U32LE = {8'h00, 8'h00, 8'hFE, 8'hFF};
   localparam logic [3:0][7:0] MARK_U32BE = {8'hFF, 8'hFE, 8'h00, 8'h00};
   localparam logic [2:0][7:0] MARK_UTF8  = {8'hBF, 8'hBB, 8'hEF};
   localparam logic [1:0][7:0] MARK_U16LE = {8'hFE, 8'hFF};
   localparam logic [1:0][7:0] MARK_U16BE = {8'hFF, 8'hFE};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [31:0] code_point;
      logic        has_code_point;
      logic [2:0]  status;
      logic [2:0]  format_in_use;
      logic        stream_done;
   } rsp_type;

   // Decoder working state; a held high surrogate keeps only its low ten bits
   typedef struct packed {
      logic [31:0] partial;
      logic [1:0]  need;
      logic [1:0]  held;
      logic        hs_vld;
      logic [9:0]  hs_bits;
      logic        last_cr;
   } utt_dec_state_type;

   typedef struct packed {
      logic [2:0]                        fmt;
      logic [SNIFF_BYTES-2:0][7:0]       sniff;
      logic [SNIFF_CW-1:0]               sniff_cnt;
      utt_dec_state_type                 dec;
      logic [2:0]                        fatal;
   } utt_state_type;

   typedef struct packed {
      logic        vld;
      logic        has;
      logic [31:0] cp;
      logic [2:0]  status;
   } utt_res_type;

   // Mark detection outcome handed to the top-level control
   typedef struct packed {
      logic       found;
      logic [2:0] fmt;
      logic       dec_en;
      logic       preload;
   } utt_mark_type;

   typedef struct packed {
      logic        vld;
      logic [31:0] cp;
      logic [2:0]  status;
      logic        last_cr;
   } utt_emit_type;

   function automatic logic utt_is_nonchar(input logic [31:0] c);
      return (c <= 32'h0010_FFFF) &&
             (((c >= 32'h0000_FDD0) && (c <= 32'h0000_FDEF)) || (c[15:1] == 15'h7FFF));
   endfunction

   function automatic logic utt_is_control(input logic [31:0] c);
      return (c != 32'h0) && ((c < 32'h20) || (c == 32'h7F)) &&
             (c != 32'h09) && (c != 32'h0A) && (c != 32'h0C) && (c != 32'h0D);
   endfunction

   // Classify a code point, fold CR/CRLF into LF, track the CR flag
   function automatic utt_emit_type utt_emit(input logic [31:0] c,
                                             input logic [2:0]  base,
                                             input logic        last_cr);
      utt_emit_type e;
      e.vld     = 1'b1;
      e.cp      = c;
      e.status  = base;
      e.last_cr = (c == 32'h0D);
      priority if (utt_is_nonchar(c)) begin
         e.status = ST_NONCHAR;
      end else if (utt_is_control(c)) begin
         e.status = ST_CONTROL;
      end else if ((c == 32'h0A) || (c == 32'h0D)) begin
         e.cp     = 32'h0A;
         e.status = ST_OK;
         e.vld    = !(last_cr && (c == 32'h0A));
      end else begin
         e.status = base;
      end
      return e;
   endfunction

endpackage

[sv/utt_mark_detect.sv]
// Byte-order-mark matcher over the held sniff bytes plus the incoming byte.
module utt_mark_detect
   import utt_pkg::*;
(
   input  logic [SNIFF_BYTES-2:0][7:0] sniff,
   input  logic [SNIFF_CW-1:0]         sniff_cnt,
   input  logic [7:0]                  data_byte,
   output utt_mark_type                mark
);

   logic [2:0] cnt_after;
   logic [7:0] v0;
   logic [7:0] v1;
   logic [7:0] v2;
   logic       m32le;
   logic       m32be;
   logic       m8;
   logic       m16le;
   logic       m16be;

   // Assemble the window: held bytes first, then the current byte
   assign cnt_after = {1'b0, sniff_cnt} + 3'd1;
   assign v0 = (sniff_cnt >= 2'd1) ? sniff[0] : data_byte;
   assign v1 = (sniff_cnt >= 2'd2) ? sniff[1] : data_byte;
   assign v2 = (sniff_cnt == 2'd3) ? sniff[2] : data_byte;

   // Match in fixed order: 32-bit marks, then UTF-8, then 16-bit marks
   assign m32le = (cnt_after == 3'd4) && ({data_byte, v2, v1, v0} == MARK_U32LE);
   assign m32be = (cnt_after == 3'd4) && ({data_byte, v2, v1, v0} == MARK_U32BE);
   assign m8    = (cnt_after >= 3'd3) && ({v2, v1, v0} == MARK_UTF8);
   assign m16le = (cnt_after >= 3'd2) && ({v1, v0} == MARK_U16LE);
   assign m16be = (cnt_after >= 3'd2) && ({v1, v0} == MARK_U16BE);

   always_comb begin
      mark = '0;
      priority if (m32le) begin
         mark.found = 1'b1;
         mark.fmt   = FMT_U32LE;
      end else if (m32be) begin
         mark.found = 1'b1;
         mark.fmt   = FMT_U32BE;
      end else if (m8) begin
         mark.found  = 1'b1;
         mark.fmt    = FMT_UTF8;
         mark.dec_en = (cnt_after == 3'd4);
      end else if (m16le || m16be) begin
         // leftover bytes after a two-byte mark: byte 2 preloads, the current one decodes
         mark.found   = 1'b1;
         mark.fmt     = m16le ? FMT_U16LE : FMT_U16BE;
         mark.dec_en  = (cnt_after >= 3'd3);
         mark.preload = (cnt_after == 3'd4);
      end else begin
         mark = '0;
      end
   end

endmodule

[sv/utt_decode.sv]
// One-byte decode step for UTF-8, UTF-16 and UTF-32 with character classification.
module utt_decode
   import utt_pkg::*;
(
   input  logic [2:0]        fmt,
   input  utt_dec_state_type cur,
   input  logic [7:0]        data_byte,
   output utt_dec_state_type nxt,
   output utt_res_type       res,
   output logic              bad_start
);

   logic [31:0]       emit_cp;
   logic [2:0]        emit_base;
   logic              emit_en;
   logic              drop_pair;
   logic [31:0]       u8_shift;
   logic [15:0]       unit;
   logic [31:0]       u32le_word;
   logic [31:0]       u32be_word;
   utt_emit_type      emit_out;
   utt_dec_state_type nxt_step;

   // Candidate words for each format
   assign u8_shift   = {cur.partial[25:0], data_byte[5:0]};
   assign unit       = (fmt == FMT_U16LE) ? {data_byte, cur.partial[7:0]}
                                          : {cur.partial[7:0], data_byte};
   assign u32le_word = cur.partial | ({24'd0, data_byte} << {cur.held, 3'b000});
   assign u32be_word = {cur.partial[23:0], data_byte};

   always_comb begin
      nxt_step  = cur;
      emit_en   = 1'b0;
      emit_cp   = '0;
      emit_base = ST_OK;
      drop_pair = 1'b0;
      bad_start = 1'b0;
      unique case (fmt)
         FMT_UTF8: begin
            if (cur.need == 2'd0) begin
               // start byte sets the length
               priority if (!data_byte[7]) begin
                  emit_en = 1'b1;
                  emit_cp = {24'd0, data_byte};
               end else if (data_byte[7:5] == 3'b110) begin
                  nxt_step.partial = {27'd0, data_byte[4:0]};
                  nxt_step.need    = 2'd1;
                  nxt_step.held    = 2'd1;
               end else if (data_byte[7:4] == 4'b1110) begin
                  nxt_step.partial = {28'd0, data_byte[3:0]};
                  nxt_step.need    = 2'd2;
                  nxt_step.held    = 2'd1;
               end else if (data_byte[7:3] == 5'b11110) begin
                  nxt_step.partial = {29'd0, data_byte[2:0]};
                  nxt_step.need    = 2'd3;
                  nxt_step.held    = 2'd1;
               end else begin
                  bad_start = 1'b1;
               end
            end else if (cur.need == 2'd1) begin
               emit_en          = 1'b1;
               emit_cp          = u8_shift;
               nxt_step.partial = '0;
               nxt_step.need    = 2'd0;
               nxt_step.held    = 2'd0;
            end else begin
               nxt_step.partial = u8_shift;
               nxt_step.need    = cur.need - 2'd1;
               nxt_step.held    = cur.held + 2'd1;
            end
         end
         FMT_U16LE, FMT_U16BE: begin
            if (cur.held == 2'd0) begin
               nxt_step.partial = {24'd0, data_byte};
               nxt_step.held    = 2'd1;
            end else begin
               nxt_step.partial = '0;
               nxt_step.held    = 2'd0;
               priority if (cur.hs_vld) begin
                  // join or drop the pair
                  nxt_step.hs_vld = 1'b0;
                  if (unit[15:10] == 6'b110111) begin
                     emit_en = 1'b1;
                     emit_cp = 32'h0001_0000 + {12'd0, cur.hs_bits, unit[9:0]};
                  end else begin
                     drop_pair = 1'b1;
                  end
               end else if (unit[15:10] == 6'b110110) begin
                  nxt_step.hs_vld  = 1'b1;
                  nxt_step.hs_bits = unit[9:0];
               end else if (unit[15:10] == 6'b110111) begin
                  emit_en   = 1'b1;
                  emit_cp   = {16'd0, unit};
                  emit_base = ST_LONE_LOW;
               end else begin
                  emit_en = 1'b1;
                  emit_cp = {16'd0, unit};
               end
            end
         end
         FMT_U32LE, FMT_U32BE: begin
            if (cur.held == 2'd3) begin
               emit_en          = 1'b1;
               emit_cp          = (fmt == FMT_U32LE) ? u32le_word : u32be_word;
               nxt_step.partial = '0;
               nxt_step.held    = 2'd0;
            end else begin
               nxt_step.partial = (fmt == FMT_U32LE) ? u32le_word : u32be_word;
               nxt_step.held    = cur.held + 2'd1;
            end
         end
         default: begin
            nxt_step = cur;
         end
      endcase
   end

   assign emit_out = utt_emit(emit_cp, emit_base, cur.last_cr);

   // Merge the emitted character or the dropped-pair report
   always_comb begin
      nxt = nxt_step;
      res = '0;
      if (emit_en) begin
         nxt.last_cr = emit_out.last_cr;
         res.vld     = emit_out.vld;
         res.has     = 1'b1;
         res.cp      = emit_out.cp;
         res.status  = emit_out.status;
      end else if (drop_pair) begin
         res.vld    = 1'b1;
         res.status = ST_BAD_PAIR;
      end
   end

endmodule

[sv/utt_rsp_fifo.sv]
// Two-entry result buffer that decouples the decode step from output stalls.
module utt_rsp_fifo
   import utt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    room,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   rsp_type    entry_ff [2];
   rsp_type    entry_in [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       pop;

   assign room      = (cnt_ff != 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   // Advance pointers and count on each transfer
   always_comb begin
      entry_in            = entry_ff;
      wr_ptr_in           = wr_ptr_ff;
      rd_ptr_in           = rd_ptr_ff;
      cnt_in              = cnt_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_data;
         wr_ptr_in           = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[sv/unicode_to_utf32_transcoder_top.sv]
// Path: a byte taken into the input register is decoded combinationally and its result, if any,
// is written into the two-entry result buffer, whose head entry drives rsp_*. Throughput: one byte
// per cycle, set by the combinational decode step between the two; it holds under output stalls
// as long as the buffer has a free entry.
// Reset (synchronous, active high): format register to auto, stream state cleared,
// input register and result buffer empty.
module unicode_to_utf32_transcoder_top
   import utt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data
);

   localparam logic [SNIFF_CW-1:0] SNIFF_LAST = SNIFF_CW'(SNIFF_BYTES - 1);

   logic              [2:0] cfg_ff;
   logic              [2:0] cfg_in;
   logic                    in_vld_ff;
   logic                    in_vld_in;
   req_type                 in_item_ff;
   req_type                 in_item_in;
   utt_state_type           state_ff;
   utt_state_type           state_in;
   utt_state_type           step_nxt;

   logic                    room;
   logic                    advance;
   logic                    accept;
   logic                    push;
   rsp_type                 push_data;
   utt_res_type             res;
   logic              [2:0] fmt_out;

   utt_mark_type            mark;
   logic                    sniff_last;
   logic                    dec_en;
   logic              [2:0] dec_fmt;
   utt_dec_state_type       dec_base;
   utt_dec_state_type       dec_nxt;
   utt_res_type             dec_res;
   logic                    bad_start;

   // Input register handshake
   assign advance   = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept || (in_vld_ff && !advance);
   assign in_item_in = accept ? req_data : in_item_ff;
   assign cfg_in     = csr_wr_en ? csr_wr_data : cfg_ff;

   utt_mark_detect u_mark (
      .sniff     (state_ff.sniff),
      .sniff_cnt (state_ff.sniff_cnt),
      .data_byte (in_item_ff.data_byte),
      .mark      (mark)
   );

   // Pick decoder format and starting state
   assign sniff_last = (state_ff.sniff_cnt == SNIFF_LAST) || in_item_ff.end_of_stream;

   always_comb begin
      dec_fmt  = state_ff.fmt;
      dec_base = state_ff.dec;
      dec_en   = 1'b0;
      if (state_ff.fatal == ST_OK) begin
         priority if (state_ff.fmt != FMT_AUTO) begin
            dec_en = 1'b1;
         end else if (cfg_ff == FMT_AUTO) begin
            if (sniff_last && mark.found) begin
               dec_fmt = mark.fmt;
               dec_en  = mark.dec_en;
               if (mark.preload) begin
                  dec_base.partial = {24'd0, state_ff.sniff[SNIFF_BYTES-2]};
                  dec_base.held    = 2'd1;
               end
            end
         end else if (cfg_ff <= FMT_U32BE) begin
            dec_fmt = cfg_ff;
            dec_en  = 1'b1;
         end else begin
            dec_en = 1'b0;
         end
      end
   end

   utt_decode u_decode (
      .fmt       (dec_fmt),
      .cur       (dec_base),
      .data_byte (in_item_ff.data_byte),
      .nxt       (dec_nxt),
      .res       (dec_res),
      .bad_start (bad_start)
   );

   // Merge sniffing, decoding, fatal errors and end of stream
   always_comb begin
      step_nxt = state_ff;
      res      = '0;
      if (state_ff.fatal == ST_OK) begin
         if (state_ff.fmt == FMT_AUTO) begin
            priority if (cfg_ff == FMT_AUTO) begin
               if (sniff_last) begin
                  step_nxt.sniff_cnt = '0;
                  if (mark.found) begin
                     step_nxt.fmt = mark.fmt;
                  end else begin
                     step_nxt.fatal = ST_UNKNOWN_FMT;
                     res.vld        = 1'b1;
                     res.status     = ST_UNKNOWN_FMT;
                  end
               end else begin
                  step_nxt.sniff[state_ff.sniff_cnt] = in_item_ff.data_byte;
                  step_nxt.sniff_cnt                 = state_ff.sniff_cnt + 1'b1;
               end
            end else if (cfg_ff <= FMT_U32BE) begin
               step_nxt.fmt = cfg_ff;
            end else begin
               step_nxt.fatal = ST_UNKNOWN_FMT;
               res.vld        = 1'b1;
               res.status     = ST_UNKNOWN_FMT;
            end
         end
         if (dec_en) begin
            step_nxt.dec = dec_nxt;
            if (bad_start) begin
               step_nxt.fatal = ST_BAD_START;
               res            = '0;
               res.vld        = 1'b1;
               res.status     = ST_BAD_START;
            end else begin
               res = dec_res;
            end
         end
         // cut-off sequence or pending high surrogate at the end
         if (in_item_ff.end_of_stream && (step_nxt.fatal == ST_OK) &&
             ((step_nxt.dec.held != 2'd0) || step_nxt.dec.hs_vld)) begin
            step_nxt.fatal = ST_INCOMPLETE;
            res            = '0;
            res.vld        = 1'b1;
            res.status     = ST_INCOMPLETE;
         end
      end
      fmt_out = step_nxt.fmt;
      if (in_item_ff.end_of_stream && !res.vld) begin
         res.vld    = 1'b1;
         res.has    = 1'b0;
         res.cp     = '0;
         res.status = step_nxt.fatal;
      end
      if (in_item_ff.end_of_stream) begin
         step_nxt = '0;
      end
   end

   assign state_in = advance ? step_nxt : state_ff;

   // Result transfer into the buffer
   assign push                     = advance && res.vld;
   assign push_data.code_point     = res.has ? res.cp : 32'd0;
   assign push_data.has_code_point = res.has;
   assign push_data.status         = res.status;
   assign push_data.format_in_use  = fmt_out;
   assign push_data.stream_done    = in_item_ff.end_of_stream;

   utt_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= FMT_AUTO;
         in_vld_ff <= 1'b0;
         state_ff  <= '0;
      end else begin
         cfg_ff    <= cfg_in;
         in_vld_ff <= in_vld_in;
         state_ff  <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   // Every last byte of a stream reports a result
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.end_of_stream) |-> push)
      else $error("end of stream processed without a result");

   // Stream state returns to its cleared form after the last byte
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.end_of_stream) |=>
         ((state_ff.fatal == ST_OK) && (state_ff.fmt == FMT_AUTO) &&
          (state_ff.sniff_cnt == '0) && (state_ff.dec.held == 2'd0) && !state_ff.dec.hs_vld))
      else $error("stream state not cleared after end of stream");

   // A pending high surrogate exists only in the UTF-16 formats
   assert property (@(posedge clock) disable iff (reset)
      state_ff.dec.hs_vld |-> ((state_ff.fmt == FMT_U16LE) || (state_ff.fmt == FMT_U16BE)))
      else $error("high surrogate held outside UTF-16");

   // Sniff bytes are held only while the format is still open
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.sniff_cnt != '0) |-> (state_ff.fmt == FMT_AUTO))
      else $error("sniff bytes held after format resolved");

endmodule

[test/utt_tb_pkg.sv]
// Scoreboard class for the transcoder bench: decodes accepted bytes and checks each result.
package utt_tb_pkg;
   import utt_pkg::*;

   // Outcome of one decode step, before it becomes a response word
   typedef struct packed {
      logic        vld;
      logic        has;
      logic [31:0] cp;
      logic [2:0]  st;
   } step_out_type;

   class code_point_checker;
      // Format register and per-stream decoder state
      logic [2:0]  format_reg;
      logic [2:0]  det_fmt;
      logic [7:0]  sniff_buf [4];
      int unsigned sniff_cnt;
      logic [31:0] partial;
      int unsigned need;
      int unsigned held;
      logic [15:0] high_sur;
      logic        last_cr;
      logic [2:0]  fatal;

      rsp_type     awaited_results [$];
      int unsigned errors;
      int unsigned bytes_seen;
      int unsigned results_seen;

      function new();
         format_reg   = FMT_AUTO;
         errors       = 0;
         bytes_seen   = 0;
         results_seen = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         det_fmt = FMT_AUTO;
         foreach (sniff_buf[i]) sniff_buf[i] = 8'h00;
         sniff_cnt = 0;
         partial   = 32'd0;
         need      = 0;
         held      = 0;
         high_sur  = 16'd0;
         last_cr   = 1'b0;
         fatal     = ST_OK;
      endfunction

      function void set_format(logic [2:0] v);
         format_reg = v;
      endfunction

      function int unsigned pending();
         return awaited_results.size();
      endfunction

      function void raise_fatal(logic [2:0] code, inout step_out_type r);
         fatal = code;
         r.vld = 1'b1;
         r.has = 1'b0;
         r.cp  = 32'd0;
         r.st  = code;
      endfunction

      function bit is_nonchar(logic [31:0] c);
         if (c > 32'h0010_FFFF) return 1'b0;
         if (c >= 32'h0000_FDD0 && c <= 32'h0000_FDEF) return 1'b1;
         return (c[15:0] | 16'h0001) == 16'hFFFF;
      endfunction

      // Classify a decoded value, fold CR and CRLF into one LF
      function void emit_cp(logic [31:0] c, logic [2:0] base, inout step_out_type r);
         bit ctrl;
         ctrl = (c != 32'd0) && ((c < 32'h20) || (c == 32'h7F)) &&
                (c != 32'h09) && (c != 32'h0A) && (c != 32'h0C) && (c != 32'h0D);
         if (is_nonchar(c)) begin
            r = '{1'b1, 1'b1, c, ST_NONCHAR};
         end else if (ctrl) begin
            r = '{1'b1, 1'b1, c, ST_CONTROL};
         end else if (c == 32'h0A || c == 32'h0D) begin
            if (!(last_cr && c == 32'h0A)) r = '{1'b1, 1'b1, 32'h0A, ST_OK};
         end else begin
            r = '{1'b1, 1'b1, c, base};
         end
         last_cr = (c == 32'h0D);
      endfunction

      // Advance the decoder of the latched encoding by one byte
      function void decode_byte(logic [7:0] b, inout step_out_type r);
         logic [31:0] unit;
         logic [31:0] c;
         int unsigned len;
         case (det_fmt)
            FMT_UTF8: begin
               if (need == 0) begin
                  if (b[7] == 1'b0) len = 1;
                  else if (b[7:5] == 3'b110) len = 2;
                  else if (b[7:4] == 4'b1110) len = 3;
                  else if (b[7:3] == 5'b11110) len = 4;
                  else len = 0;
                  if (len == 0) begin
                     raise_fatal(ST_BAD_START, r);
                     return;
                  end
                  if (len == 1) begin
                     emit_cp({24'd0, b}, ST_OK, r);
                     return;
                  end
                  partial = 32'(b & ((len == 2) ? 8'h1F : (len == 3) ? 8'h0F : 8'h07));
                  need    = len - 1;
                  held    = 1;
               end else begin
                  // continuation bits go in unchecked
                  partial = {partial[25:0], b[5:0]};
                  held++;
                  need--;
                  if (need == 0) begin
                     held    = 0;
                     unit    = partial;
                     partial = 32'd0;
                     emit_cp(unit, ST_OK, r);
                  end
               end
            end
            FMT_U16LE, FMT_U16BE: begin
               if (held == 0) begin
                  partial = 32'(b);
                  held    = 1;
                  return;
               end
               unit = (det_fmt == FMT_U16LE) ? {16'd0, b, partial[7:0]} :
                                               {16'd0, partial[7:0], b};
               held    = 0;
               partial = 32'd0;
               if (high_sur != 16'd0) begin
                  if (unit >= 32'hDC00 && unit <= 32'hDFFF) begin
                     c = 32'h1_0000 + ((32'(high_sur) - 32'hD800) << 10) + (unit - 32'hDC00);
                     high_sur = 16'd0;
                     emit_cp(c, ST_OK, r);
                  end else begin
                     // drop the pair
                     high_sur = 16'd0;
                     r = '{1'b1, 1'b0, 32'd0, ST_BAD_PAIR};
                  end
               end else if (unit >= 32'hD800 && unit <= 32'hDBFF) begin
                  high_sur = unit[15:0];
               end else if (unit >= 32'hDC00 && unit <= 32'hDFFF) begin
                  emit_cp(unit, ST_LONE_LOW, r);
               end else begin
                  emit_cp(unit, ST_OK, r);
               end
            end
            FMT_U32LE, FMT_U32BE: begin
               if (det_fmt == FMT_U32LE) partial = partial | (32'(b) << (8 * (held % 4)));
               else partial = {partial[23:0], b};
               held++;
               if (held >= 4) begin
                  unit    = partial;
                  partial = 32'd0;
                  held    = 0;
                  emit_cp(unit, ST_OK, r);
               end
            end
            default: ;
         endcase
      endfunction

      function bit head_is(int unsigned n, logic [7:0] b0, logic [7:0] b1,
                           logic [7:0] b2, logic [7:0] b3);
         logic [7:0] pat [4];
         pat = '{b0, b1, b2, b3};
         if (sniff_cnt < n) return 1'b0;
         for (int i = 0; i < n; i++) if (sniff_buf[i] != pat[i]) return 1'b0;
         return 1'b1;
      endfunction

      // Resolve the byte-order mark, then decode what follows it in the window
      function void run_sniff(inout step_out_type r);
         int unsigned  skip;
         step_out_type t;
         if (head_is(4, 8'hFF, 8'hFE, 8'h00, 8'h00)) begin
            det_fmt = FMT_U32LE;
            skip    = 4;
         end else if (head_is(4, 8'h00, 8'h00, 8'hFE, 8'hFF)) begin
            det_fmt = FMT_U32BE;
            skip    = 4;
         end else if (head_is(3, 8'hEF, 8'hBB, 8'hBF, 8'h00)) begin
            det_fmt = FMT_UTF8;
            skip    = 3;
         end else if (head_is(2, 8'hFF, 8'hFE, 8'h00, 8'h00)) begin
            det_fmt = FMT_U16LE;
            skip    = 2;
         end else if (head_is(2, 8'hFE, 8'hFF, 8'h00, 8'h00)) begin
            det_fmt = FMT_U16BE;
            skip    = 2;
         end else begin
            raise_fatal(ST_UNKNOWN_FMT, r);
            return;
         end
         for (int unsigned i = skip; i < sniff_cnt && i < 4 && fatal == ST_OK; i++) begin
            t = '0;
            decode_byte(sniff_buf[i], t);
            if (t.vld) r = t;
         end
      endfunction

      // Work out what one accepted byte produces and queue it
      function void note_byte(req_type item);
         step_out_type r;
         logic [7:0]   b;
         logic         eos;
         logic [2:0]   fmt_now;
         rsp_type      e;
         r   = '0;
         b   = item.data_byte;
         eos = item.end_of_stream;
         bytes_seen++;
         if (fatal == ST_OK) begin
            if (det_fmt == FMT_AUTO) begin
               if (format_reg == FMT_AUTO) begin
                  if (sniff_cnt < 4) begin
                     sniff_buf[sniff_cnt] = b;
                     sniff_cnt++;
                  end
                  if (sniff_cnt >= 4 || eos) run_sniff(r);
               end else if (format_reg <= FMT_U32BE) begin
                  det_fmt = format_reg;
                  decode_byte(b, r);
               end else begin
                  raise_fatal(ST_UNKNOWN_FMT, r);
               end
            end else begin
               decode_byte(b, r);
            end
            if (eos && fatal == ST_OK && (held != 0 || high_sur != 16'd0))
               raise_fatal(ST_INCOMPLETE, r);
         end
         fmt_now = det_fmt;
         if (eos && !r.vld) r = '{1'b1, 1'b0, 32'd0, fatal};
         if (eos) clear_stream();
         if (r.vld) begin
            e.code_point     = r.has ? r.cp : 32'd0;
            e.has_code_point = r.has;
            e.status         = r.st;
            e.format_in_use  = fmt_now;
            e.stream_done    = eos;
            awaited_results.push_back(e);
         end
      endfunction

      // Compare one accepted result against the oldest awaited one
      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (awaited_results.size() == 0) begin
            $error("result with nothing awaited: %h", got);
            errors++;
            return;
         end
         want = awaited_results[0];
         awaited_results.delete(0);
         if (got.code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, got.code_point);
            errors++;
         end
         if (got.has_code_point !== want.has_code_point) begin
            $error("has_code_point: expected %b, got %b", want.has_code_point,
                   got.has_code_point);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.format_in_use !== want.format_in_use) begin
            $error("format_in_use: expected %0d, got %0d", want.format_in_use,
                   got.format_in_use);
            errors++;
         end
         if (got.stream_done !== want.stream_done) begin
            $error("stream_done: expected %b, got %b", want.stream_done, got.stream_done);
            errors++;
         end
      endfunction
   endclass

endpackage

[test/tb.sv]
// Testbench top: drives byte streams in every format setting and checks decoded results.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import utt_pkg::*;
   import utt_tb_pkg::*;

   // Register values past the last encoding
   localparam logic [2:0] FMT_RSVD6 = 3'd6;
   localparam logic [2:0] FMT_RSVD7 = 3'd7;

   localparam int unsigned NUM_PHASES    = 15;
   localparam int unsigned HOLD_CYCLES   = 64;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES   = 8;
   localparam int unsigned QUIET_LIMIT   = 2000;

   typedef logic [7:0] byte_q_type [$];

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   req_type    req_data    = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en   = 1'b0;
   logic [2:0] csr_wr_data = 3'd0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   bit          hold_request  = 1'b0;

   code_point_checker sb;

   unicode_to_utf32_transcoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Check each result transfer, then drive the stall for the next cycle
   initial begin : receiver
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // End the run when no transfer happens for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("timeout: no transfer in %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // Offer one byte, with optional idle cycles first, and hold it until taken
   task automatic send_byte(input logic [7:0] b, input logic eos);
      req_type item;
      item.data_byte     = b;
      item.end_of_stream = eos;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(item);
   endtask

   task automatic send_stream(input byte_q_type q);
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
   endtask

   // Drop valid and wait for every awaited result
   task automatic wait_results_done();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_format(input logic [2:0] v);
      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_format(v);
   endtask

   function automatic logic [31:0] pick_code_point();
      case ($urandom_range(0, 15))
         0:       return 32'h0D;
         1:       return 32'h0A;
         2:       return ($urandom_range(0, 7) == 0) ? 32'h7F : 32'($urandom_range(0, 31));
         3:       return 32'($urandom_range(32'hFDD0, 32'hFDEF));
         4:       return {11'd0, 5'($urandom_range(0, 16)), 15'h7FFF, 1'($urandom_range(0, 1))};
         5:       return 32'($urandom_range(32'hD800, 32'hDFFF));
         8, 9:    return 32'($urandom_range(32'h80, 32'hFFFF));
         10, 11:  return 32'($urandom_range(32'h1_0000, 32'h10_FFFF));
         12:      return $urandom_range(0, 1) ? 32'h0 : 32'h10_FFFF;
         13:      return $urandom();
         default: return 32'($urandom_range(32'h20, 32'h7E));
      endcase
   endfunction

   function automatic void push_unit16(input logic [2:0] enc, input logic [15:0] u,
                                       ref byte_q_type q);
      if (enc == FMT_U16LE) begin
         q.push_back(u[7:0]);
         q.push_back(u[15:8]);
      end else begin
         q.push_back(u[15:8]);
         q.push_back(u[7:0]);
      end
   endfunction

   function automatic void encode_cp(input logic [2:0] enc, input logic [31:0] cp,
                                     ref byte_q_type q);
      logic [20:0] c;
      logic [31:0] v;
      case (enc)
         FMT_UTF8: begin
            c = cp[20:0];
            if (c < 21'h80) begin
               q.push_back(c[7:0]);
            end else if (c < 21'h800) begin
               q.push_back({3'b110, c[10:6]});
               q.push_back({2'b10, c[5:0]});
            end else if (c < 21'h1_0000) begin
               q.push_back({4'b1110, c[15:12]});
               q.push_back({2'b10, c[11:6]});
               q.push_back({2'b10, c[5:0]});
            end else begin
               q.push_back({5'b11110, c[20:18]});
               q.push_back({2'b10, c[17:12]});
               q.push_back({2'b10, c[11:6]});
               q.push_back({2'b10, c[5:0]});
            end
         end
         FMT_U16LE, FMT_U16BE: begin
            v = (cp > 32'h10_FFFF) ? {16'd0, cp[15:0]} : cp;
            if (v < 32'h1_0000) begin
               push_unit16(enc, v[15:0], q);
            end else begin
               v = v - 32'h1_0000;
               push_unit16(enc, {6'b110110, v[19:10]}, q);
               push_unit16(enc, {6'b110111, v[9:0]}, q);
            end
         end
         FMT_U32LE: begin
            q.push_back(cp[7:0]);
            q.push_back(cp[15:8]);
            q.push_back(cp[23:16]);
            q.push_back(cp[31:24]);
         end
         default: begin
            q.push_back(cp[31:24]);
            q.push_back(cp[23:16]);
            q.push_back(cp[15:8]);
            q.push_back(cp[7:0]);
         end
      endcase
   endfunction

   function automatic void push_mark(input logic [2:0] enc, ref byte_q_type q);
      case (enc)
         FMT_UTF8:  q = {q, 8'hEF, 8'hBB, 8'hBF};
         FMT_U16LE: q = {q, 8'hFF, 8'hFE};
         FMT_U16BE: q = {q, 8'hFE, 8'hFF};
         FMT_U32LE: q = {q, 8'hFF, 8'hFE, 8'h00, 8'h00};
         default:   q = {q, 8'h00, 8'h00, 8'hFE, 8'hFF};
      endcase
   endfunction

   // Mostly well-formed streams with random content; some broken or cut short
   function automatic void build_stream(input logic [2:0] reg_fmt, ref byte_q_type q);
      logic [2:0]  enc;
      logic [31:0] cp;
      q.delete();
      if (reg_fmt > FMT_U32BE) begin
         repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
         return;
      end
      enc = reg_fmt;
      if (reg_fmt == FMT_AUTO) begin
         enc = 3'($urandom_range(1, 5));
         push_mark(enc, q);
         if ($urandom_range(0, 99) < 15) begin
            // missing or cut-off mark
            if ($urandom_range(0, 1)) q.delete();
            else repeat ($urandom_range(0, q.size() - 1)) void'(q.pop_back());
            repeat ($urandom_range((q.size() == 0) ? 1 : 0, 3)) q.push_back(8'($urandom));
            return;
         end
      end
      repeat ($urandom_range(1, 8)) begin
         if ($urandom_range(0, 24) == 0) begin
            if (enc == FMT_U16LE || enc == FMT_U16BE)
               push_unit16(enc, 16'($urandom_range(16'hD800, 16'hDBFF)), q);
            else
               q.push_back(8'($urandom));
         end
         cp = pick_code_point();
         encode_cp(enc, cp, q);
         if (cp == 32'h0D && $urandom_range(0, 1)) encode_cp(enc, 32'h0A, q);
      end
      if ($urandom_range(0, 11) == 0 && q.size() > 1) void'(q.pop_back());
   endfunction

   initial begin : main_seq
      byte_q_type  stream;
      logic [2:0]  phase_fmt [NUM_PHASES];
      int unsigned phase_bytes;
      int unsigned in_phase;
      int unsigned streams_sent;
      sb = new();
      streams_sent = 0;
      phase_fmt = '{FMT_AUTO, FMT_UTF8, FMT_U16LE, FMT_U16BE, FMT_U32LE, FMT_U32BE,
                    FMT_RSVD7, FMT_AUTO, FMT_UTF8, FMT_U16LE, FMT_RSVD6, FMT_U16BE,
                    FMT_AUTO, FMT_U32BE, FMT_U32LE};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      write_format(FMT_AUTO);

      // Directed: UTF-8, UTF-32 and UTF-16BE marks, CRLF folding, control, nonchar, pair, bare mark, no mark
      stream = {8'hEF, 8'hBB, 8'hBF, 8'h0D, 8'h0A, 8'h7F};
      send_stream(stream);
      stream = {8'hFF, 8'hFE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h10, 8'h00};
      send_stream(stream);
      stream = {8'hFE, 8'hFF, 8'hD8, 8'h00, 8'hDC, 8'h00};
      send_stream(stream);
      stream = {8'h00, 8'h00, 8'hFE, 8'hFF};
      send_stream(stream);
      stream = {8'hFF};
      send_stream(stream);
      streams_sent += 5;

      // Random phases: one format setting and one idling mix each
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_format(phase_fmt[p]);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 51;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 51;
            end
            default: begin
               send_idle_pct = 10;
               stall_pct     = 10;
            end
         endcase
         phase_bytes = 0;
         in_phase    = 0;
         while (phase_bytes < ((phase_fmt[p] > FMT_U32BE) ? 20 : 90)) begin
            build_stream(phase_fmt[p], stream);
            send_stream(stream);
            phase_bytes += stream.size();
            in_phase++;
            // back-pressure: long receiver hold while bytes keep coming
            if (in_phase == 2 && p % 3 == 1) hold_request = 1'b1;
            // pause the sender until the block has drained
            if (in_phase == 4 && p % 3 == 2) wait_results_done();
         end
         streams_sent += in_phase;
      end

      wait_results_done();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d bytes in %0d streams over %0d format settings (auto, all five",
               sb.bytes_seen, streams_sent, NUM_PHASES + 1);
      $display("encodings, reserved codes); checked %0d results under gaps and stalls.",
               sb.results_seen);
      if (sb.pending() != 0) $error("%0d awaited results never arrived", sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
